@@ sv/lidc_pkg.sv @@
package lidc_pkg;

  localparam int COORD_BITS = 24;
  localparam int INDEX_BITS = 20;

  localparam int DIFF_BITS  = COORD_BITS + 1;
  localparam int PROD_BITS  = 2 * DIFF_BITS;
  localparam int CROSS_BITS = PROD_BITS + 1;
  localparam int LEN2_BITS  = PROD_BITS;
  localparam int ROOT_BITS  = LEN2_BITS / 2;
  localparam int DIST_BITS  = COORD_BITS + 1;
  localparam int COUNT_BITS = INDEX_BITS + 1;
  localparam int SUB_BITS   = ROOT_BITS + 3;

  localparam int MUL_STEPS  = 4;
  localparam int SQRT_STEPS = LEN2_BITS / 2;
  localparam int DIV_STEPS  = DIST_BITS;
  localparam int STEP_MAX   = (SQRT_STEPS > DIV_STEPS) ? SQRT_STEPS : DIV_STEPS;
  localparam int CNT_BITS   = $clog2(STEP_MAX + 1);

  localparam logic [DIST_BITS-1:0]  DIST_MAX  = '1;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = COORD_BITS;

  localparam logic [CFG_IDX_BITS-1:0] REG_LINE_START_X       = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_LINE_START_Y       = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_LINE_END_X         = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_LINE_END_Y         = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_DISTANCE_THRESHOLD = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_BOUNDARY_INCLUSIVE = 3'd5;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_ABS,
    ST_SQRT,
    ST_DIVCHK,
    ST_DIV,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic                load;
    state_t              phase;
    logic [CNT_BITS-1:0] cnt;
  } ctl_t;

endpackage

@@ sv/lidc_if.sv @@
interface lidc_point_if;
  logic                                    valid;
  logic                                    ready;
  logic signed [lidc_pkg::COORD_BITS-1:0]  point_x;
  logic signed [lidc_pkg::COORD_BITS-1:0]  point_y;
  logic        [lidc_pkg::INDEX_BITS-1:0]  point_index;
  logic                                    last_point;

  modport source(output valid, point_x, point_y, point_index, last_point, input ready);
  modport sink(input valid, point_x, point_y, point_index, last_point, output ready);
endinterface

interface lidc_result_if;
  logic                             valid;
  logic                             ready;
  logic [lidc_pkg::INDEX_BITS-1:0]  out_index;
  logic [lidc_pkg::DIST_BITS-1:0]   distance;
  logic                             is_inlier;
  logic [lidc_pkg::COUNT_BITS-1:0]  inlier_count;
  logic                             degenerate_line;
  logic                             last;

  modport source(output valid, out_index, distance, is_inlier, inlier_count,
                 degenerate_line, last, input ready);
  modport sink(input valid, out_index, distance, is_inlier, inlier_count,
               degenerate_line, last, output ready);
endinterface

@@ sv/lidc_sub.sv @@
// Shared trial subtractor used by both the square root and the divider steps.
module lidc_sub (
  input  logic [lidc_pkg::SUB_BITS-1:0] a,
  input  logic [lidc_pkg::SUB_BITS-1:0] b,
  output logic [lidc_pkg::SUB_BITS-1:0] diff,
  output logic                          ge
);

  logic [lidc_pkg::SUB_BITS:0] full;

  always_comb begin
    full = {1'b0, a} - {1'b0, b};
    diff = full[lidc_pkg::SUB_BITS-1:0];
    ge   = ~full[lidc_pkg::SUB_BITS];
  end

endmodule

@@ sv/lidc_seq.sv @@
module lidc_seq (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  logic            out_free,
  output logic            in_ready,
  output logic            done,
  output lidc_pkg::ctl_t  ctl
);

  lidc_pkg::state_t              state, state_next;
  logic [lidc_pkg::CNT_BITS-1:0] cnt, cnt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lidc_pkg::ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  always_comb begin
    state_next = state;
    cnt_next   = cnt + 1'b1;
    case (state)
      lidc_pkg::ST_IDLE: begin
        cnt_next = '0;
        if (in_valid) begin
          state_next = lidc_pkg::ST_MUL;
        end
      end
      lidc_pkg::ST_MUL: begin
        // The state is held on after the last product so that it can be folded into the sums.
        if (cnt == lidc_pkg::CNT_BITS'(lidc_pkg::MUL_STEPS)) begin
          state_next = lidc_pkg::ST_ABS;
          cnt_next   = '0;
        end
      end
      lidc_pkg::ST_ABS: begin
        state_next = lidc_pkg::ST_SQRT;
        cnt_next   = '0;
      end
      lidc_pkg::ST_SQRT: begin
        if (cnt == lidc_pkg::CNT_BITS'(lidc_pkg::SQRT_STEPS - 1)) begin
          state_next = lidc_pkg::ST_DIVCHK;
          cnt_next   = '0;
        end
      end
      lidc_pkg::ST_DIVCHK: begin
        state_next = lidc_pkg::ST_DIV;
        cnt_next   = '0;
      end
      lidc_pkg::ST_DIV: begin
        if (cnt == lidc_pkg::CNT_BITS'(lidc_pkg::DIV_STEPS - 1)) begin
          state_next = lidc_pkg::ST_DONE;
          cnt_next   = '0;
        end
      end
      lidc_pkg::ST_DONE: begin
        cnt_next = '0;
        if (out_free) begin
          state_next = lidc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = lidc_pkg::ST_IDLE;
        cnt_next   = '0;
      end
    endcase
  end

  always_comb begin
    in_ready  = (state == lidc_pkg::ST_IDLE) && !rst;
    done      = (state == lidc_pkg::ST_DONE) && out_free;
    ctl.load  = in_ready && in_valid;
    ctl.phase = state;
    ctl.cnt   = cnt;
  end

endmodule

@@ sv/lidc_dp.sv @@
module lidc_dp (
  input  logic                                   clk,
  input  lidc_pkg::ctl_t                         ctl,
  input  logic [lidc_pkg::COORD_BITS-1:0]        line_start_x,
  input  logic [lidc_pkg::COORD_BITS-1:0]        line_start_y,
  input  logic [lidc_pkg::COORD_BITS-1:0]        line_end_x,
  input  logic [lidc_pkg::COORD_BITS-1:0]        line_end_y,
  input  logic [lidc_pkg::COORD_BITS-1:0]        point_x,
  input  logic [lidc_pkg::COORD_BITS-1:0]        point_y,
  input  logic [lidc_pkg::INDEX_BITS-1:0]        point_index,
  input  logic                                   last_point,
  output logic [lidc_pkg::DIST_BITS-1:0]         dist_val,
  output logic                                   degen,
  output logic [lidc_pkg::INDEX_BITS-1:0]        index,
  output logic                                   last
);

  localparam int CM = lidc_pkg::COORD_BITS - 1;
  localparam int RB = lidc_pkg::ROOT_BITS;
  localparam int DB = lidc_pkg::DIST_BITS;
  localparam int LB = lidc_pkg::LEN2_BITS;

  logic signed [lidc_pkg::DIFF_BITS-1:0]  dx, dy, px, py;
  logic signed [lidc_pkg::DIFF_BITS-1:0]  mul_a, mul_b;
  logic signed [lidc_pkg::PROD_BITS-1:0]  prod;
  logic signed [lidc_pkg::CROSS_BITS-1:0] prod_ext;
  logic signed [lidc_pkg::CROSS_BITS-1:0] cross_sum;
  logic        [lidc_pkg::CROSS_BITS-1:0] cross_abs;
  logic        [LB-1:0]                   len2;
  logic        [LB-1:0]                   rad;
  logic        [RB:0]                     rem;
  logic        [RB-1:0]                   root;
  logic        [DB-1:0]                   quo;
  logic                                   sat;

  logic [lidc_pkg::SUB_BITS-1:0] sub_a, sub_b, sub_diff;
  logic                          sub_ge;

  lidc_sub u_sub (
    .a    (sub_a),
    .b    (sub_b),
    .diff (sub_diff),
    .ge   (sub_ge)
  );

  // Product order: dx*py, dy*px, dx*dx, dy*dy.
  always_comb begin
    case (ctl.cnt[1:0])
      2'd0: begin
        mul_a = dx;
        mul_b = py;
      end
      2'd1: begin
        mul_a = dy;
        mul_b = px;
      end
      2'd2: begin
        mul_a = dx;
        mul_b = dx;
      end
      default: begin
        mul_a = dy;
        mul_b = dy;
      end
    endcase
    prod_ext = {prod[lidc_pkg::PROD_BITS-1], prod};
  end

  always_comb begin
    if (ctl.phase == lidc_pkg::ST_SQRT) begin
      sub_a = {rem, rad[LB-1 -: 2]};
      sub_b = {1'b0, root, 2'b01};
    end else begin
      sub_a = {2'b00, rem[RB-1:0], quo[DB-1]};
      sub_b = {3'b000, root};
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      dx    <= {line_end_x[CM], line_end_x} - {line_start_x[CM], line_start_x};
      dy    <= {line_end_y[CM], line_end_y} - {line_start_y[CM], line_start_y};
      px    <= {point_x[CM], point_x} - {line_start_x[CM], line_start_x};
      py    <= {point_y[CM], point_y} - {line_start_y[CM], line_start_y};
      degen <= (line_end_x == line_start_x) && (line_end_y == line_start_y);
      index <= point_index;
      last  <= last_point;
    end

    case (ctl.phase)
      lidc_pkg::ST_MUL: begin
        if (ctl.cnt < lidc_pkg::CNT_BITS'(lidc_pkg::MUL_STEPS)) begin
          prod <= mul_a * mul_b;
        end
        case (ctl.cnt)
          lidc_pkg::CNT_BITS'(1): cross_sum <= prod_ext;
          lidc_pkg::CNT_BITS'(2): cross_sum <= cross_sum - prod_ext;
          lidc_pkg::CNT_BITS'(3): len2      <= prod;
          lidc_pkg::CNT_BITS'(4): len2      <= len2 + prod;
          default: ;
        endcase
      end
      lidc_pkg::ST_ABS: begin
        cross_abs <= cross_sum[lidc_pkg::CROSS_BITS-1] ? -cross_sum : cross_sum;
        rad       <= len2;
        rem       <= '0;
        root      <= '0;
      end
      lidc_pkg::ST_SQRT: begin
        // Digit-by-digit root, two radicand bits per step.
        rad  <= {rad[LB-3:0], 2'b00};
        root <= {root[RB-2:0], sub_ge};
        rem  <= sub_ge ? sub_diff[RB:0] : sub_a[RB:0];
      end
      lidc_pkg::ST_DIVCHK: begin
        // A quotient that would not fit the distance field saturates.
        sat <= cross_abs >= {1'b0, root, {DB{1'b0}}};
        rem <= {1'b0, cross_abs[RB+DB-1:DB]};
        quo <= cross_abs[DB-1:0];
      end
      lidc_pkg::ST_DIV: begin
        quo <= {quo[DB-2:0], sub_ge};
        rem <= sub_ge ? sub_diff[RB:0] : sub_a[RB:0];
      end
      default: ;
    endcase
  end

  assign dist_val = (sat || degen) ? lidc_pkg::DIST_MAX : quo;

endmodule

@@ sv/line_inlier_distance_count.sv @@
// One item is in work at a time: a new item is accepted only once the result of the
// last one has been passed to the output register. The shared multiplier (4
// products), the 25-step square root and the 25-step divider run in turn, and the
// square root and the divider share one trial subtractor.
// Reset (rst, synchronous, active high) clears the sequencer, the output valid,
// the running inlier count and the line registers; boundary_inclusive resets to 1.
module line_inlier_distance_count (
  input  logic                                  clk,
  input  logic                                  rst,
  lidc_point_if.sink                            point,
  lidc_result_if.source                         result,
  input  logic                                  cfg_wr_en,
  input  logic [lidc_pkg::CFG_IDX_BITS-1:0]     cfg_index,
  input  logic [lidc_pkg::CFG_DATA_BITS-1:0]    cfg_data
);

  logic [lidc_pkg::COORD_BITS-1:0] line_start_x, line_start_y;
  logic [lidc_pkg::COORD_BITS-1:0] line_end_x, line_end_y;
  logic [lidc_pkg::COORD_BITS-1:0] distance_threshold;
  logic                            boundary_inclusive;

  logic [lidc_pkg::COUNT_BITS-1:0] running_count, running_count_next;

  lidc_pkg::ctl_t                  ctl;
  logic                            out_free, done, in_ready;
  logic [lidc_pkg::DIST_BITS-1:0]  item_dist;
  logic                            degen, item_last, inlier;
  logic [lidc_pkg::INDEX_BITS-1:0] item_index;
  logic [lidc_pkg::DIST_BITS-1:0]  thr_ext;

  always_ff @(posedge clk) begin
    if (rst) begin
      line_start_x       <= '0;
      line_start_y       <= '0;
      line_end_x         <= '0;
      line_end_y         <= '0;
      distance_threshold <= '0;
      boundary_inclusive <= 1'b1;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        lidc_pkg::REG_LINE_START_X:       line_start_x       <= cfg_data;
        lidc_pkg::REG_LINE_START_Y:       line_start_y       <= cfg_data;
        lidc_pkg::REG_LINE_END_X:         line_end_x         <= cfg_data;
        lidc_pkg::REG_LINE_END_Y:         line_end_y         <= cfg_data;
        lidc_pkg::REG_DISTANCE_THRESHOLD: distance_threshold <= cfg_data;
        lidc_pkg::REG_BOUNDARY_INCLUSIVE: boundary_inclusive <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign out_free    = !result.valid || result.ready;
  assign point.ready = in_ready;

  lidc_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .in_valid (point.valid),
    .out_free (out_free),
    .in_ready (in_ready),
    .done     (done),
    .ctl      (ctl)
  );

  lidc_dp u_dp (
    .clk          (clk),
    .ctl          (ctl),
    .line_start_x (line_start_x),
    .line_start_y (line_start_y),
    .line_end_x   (line_end_x),
    .line_end_y   (line_end_y),
    .point_x      (point.point_x),
    .point_y      (point.point_y),
    .point_index  (point.point_index),
    .last_point   (point.last_point),
    .dist_val     (item_dist),
    .degen        (degen),
    .index        (item_index),
    .last         (item_last)
  );

  always_comb begin
    thr_ext = {1'b0, distance_threshold};
    if (degen) begin
      inlier = 1'b0;
    end else if (boundary_inclusive) begin
      inlier = (item_dist <= thr_ext);
    end else begin
      inlier = (item_dist < thr_ext);
    end
    running_count_next = running_count;
    if (inlier && (running_count != lidc_pkg::COUNT_MAX)) begin
      running_count_next = running_count + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid  <= 1'b0;
      running_count <= '0;
    end else if (done) begin
      result.valid  <= 1'b1;
      running_count <= item_last ? '0 : running_count_next;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      result.out_index       <= item_index;
      result.distance        <= item_dist;
      result.is_inlier       <= inlier;
      result.inlier_count    <= running_count_next;
      result.degenerate_line <= degen;
      result.last            <= item_last;
    end
  end

endmodule

@@ sv/lidc_checker.sv @@
module lidc_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            in_valid,
  input logic                            in_ready,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic [lidc_pkg::DIST_BITS-1:0]  distance,
  input logic                            is_inlier,
  input logic [lidc_pkg::COUNT_BITS-1:0] inlier_count,
  input logic                            degenerate_line
);

  // The block works on one item at a time.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input taken again while an item is in work");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(distance)))
    else $error("stalled result changed");

  a_degen_result: assert property (@(posedge clk) disable iff (rst)
    (out_valid && degenerate_line) |->
      (!is_inlier && (distance == lidc_pkg::DIST_MAX)))
    else $error("zero-length line gave an inlier or a finite distance");

  a_inlier_counted: assert property (@(posedge clk) disable iff (rst)
    (out_valid && is_inlier) |-> (inlier_count != '0))
    else $error("inlier reported with zero count");

endmodule

bind line_inlier_distance_count lidc_checker u_lidc_checker (
  .clk             (clk),
  .rst             (rst),
  .in_valid        (point.valid),
  .in_ready        (point.ready),
  .out_valid       (result.valid),
  .out_ready       (result.ready),
  .distance        (result.distance),
  .is_inlier       (result.is_inlier),
  .inlier_count    (result.inlier_count),
  .degenerate_line (result.degenerate_line)
);
